// File: hdl/afrb_pkg.sv
// Shared types and constants for the audio frame ring buffer.
// Depends on nothing; every other file of the block but afrb_ram imports it.
`default_nettype none

package afrb_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2
    } opcode_t;

    // Configuration register indexes
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 1'b1;

    // Field widths
    localparam int SAMPLE_W     = 32;
    localparam int CFG_CH_W     = 4;
    localparam int CFG_FRAMES_W = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int FILL_W       = 11;

    // Reset values of the configuration registers
    localparam logic [CFG_CH_W-1:0]     CHANNELS_RESET = 4'd2;
    localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET   = 11'd1024;

    // Result queue depth: covers the read stage plus a waiting and a fresh result
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        opcode_t               opcode;
        logic [SAMPLE_W-1:0]   sample;
        logic                  last_of_batch;
        logic                  writer_streaming;
        logic                  reader_streaming;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample_out;
        logic                  read_served;
        logic                  underrun;
        logic                  overrun_drop;
        logic [FILL_W-1:0]     fill_frames;
        logic                  last;
    } out_item_t;

endpackage

`default_nettype wire

// File: hdl/afrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module afrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/afrb_out_fifo.sv
// Small result queue in front of the result channel.
// Depends on afrb_pkg for the result type and queue depth.
`default_nettype none

module afrb_out_fifo
    import afrb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_valid,
    input  wire out_item_t            push_data,
    input  wire logic                 pop_ready,
    output logic                      pop_valid,
    output out_item_t                 pop_data,
    output logic [OUT_LVL_W-1:0]      level
);

    out_item_t              q_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   head_reg, head_next;
    logic [OUT_PTR_W-1:0]   tail_reg, tail_next;
    logic [OUT_LVL_W-1:0]   level_reg, level_next;
    logic                   pop;

    assign pop       = pop_ready && (level_reg != '0);
    assign pop_valid = (level_reg != '0);
    assign pop_data  = q_reg[head_reg];
    assign level     = level_reg;

    // Advance pointers and occupancy
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        if (pop) begin
            head_next = (head_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_valid) begin
            tail_next = (tail_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push_valid && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push_valid && pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            q_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/audio_frame_ring_buffer_unit.sv
// Audio frame ring buffer: interleaved multi-channel samples, one sample per transaction.
// Depends on afrb_pkg, afrb_ram and afrb_out_fifo.
//
// Usage:
//   s_valid/s_ready/s_data carry one transaction: write a sample, read a sample or
//   flush. m_valid/m_ready/m_data return exactly one result per input transaction,
//   in order. Samples live in one sample RAM of FRAME_SLOTS*MAX_CHANNELS words;
//   sample c of frame f sits at word f*MAX_CHANNELS + c. All pointers and the
//   frame count are registers, updated in the accept cycle, so a new transaction
//   can be taken every cycle while s_ready is high.
//   Path: a result is registered in the read stage (RAM read), then in the result
//   queue, before it appears on m_valid.
//   Throughput: one item per cycle while s_ready is high, at most one RAM access each.
//   Stall: a three-entry result queue absorbs the RAM read stage; s_ready stays high
//   while one result waits, and drops once the queue and read stage together hold three.
//   Reset: channels returns to 2, the frame capacity to 1024, all pointers and the
//   frame count clear. The RAM is not cleared; a read only reaches words written
//   since the last flush. A cfg write must come only while idle (not enforced); it clears all pointers.
`default_nettype none

module audio_frame_ring_buffer_unit
    import afrb_pkg::*;
#(
    parameter int FRAME_SLOTS  = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    localparam int STORE_WORDS = FRAME_SLOTS * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int FRAME_W     = $clog2(FRAME_SLOTS);
    localparam int CHP_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CAP_W       = ($clog2(FRAME_SLOTS + 1) > CFG_FRAMES_W) ?
                                 $clog2(FRAME_SLOTS + 1) : CFG_FRAMES_W;
    localparam int CHN_W       = ($clog2(MAX_CHANNELS + 1) > CFG_CH_W) ?
                                 $clog2(MAX_CHANNELS + 1) : CFG_CH_W;

    // Configuration registers
    logic [CFG_CH_W-1:0]     cfg_ch_reg;
    logic [CFG_FRAMES_W-1:0] cfg_frames_reg;

    // Pointer state
    logic [FRAME_W-1:0] wr_frame_reg, wr_frame_next;
    logic [CHP_W-1:0]   wr_chan_reg,  wr_chan_next;
    logic [FRAME_W-1:0] rd_frame_reg, rd_frame_next;
    logic [CHP_W-1:0]   rd_chan_reg,  rd_chan_next;
    logic [CAP_W-1:0]   count_reg,    count_next;

    // Read stage
    logic               a_valid_reg;
    out_item_t          a_item_reg, a_item_next;
    logic               a_use_ram_reg, a_use_ram_next;

    // RAM ports
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Result queue
    out_item_t               push_item;
    logic [OUT_LVL_W-1:0]    q_level;
    logic [OUT_LVL_W:0]      in_flight;

    logic                s_accept;
    logic [CHN_W-1:0]    ch_eff;
    logic [CAP_W-1:0]    cap_eff;

    // Effective channel count and capacity, clipped to the supported range
    always_comb begin
        if (cfg_ch_reg == '0) begin
            ch_eff = CHN_W'(1);
        end else if (CHN_W'(cfg_ch_reg) > CHN_W'(MAX_CHANNELS)) begin
            ch_eff = CHN_W'(MAX_CHANNELS);
        end else begin
            ch_eff = CHN_W'(cfg_ch_reg);
        end
        if (cfg_frames_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (CAP_W'(cfg_frames_reg) > CAP_W'(FRAME_SLOTS)) begin
            cap_eff = CAP_W'(FRAME_SLOTS);
        end else begin
            cap_eff = CAP_W'(cfg_frames_reg);
        end
    end

    function automatic logic [FRAME_W-1:0] next_frame(
        input logic [FRAME_W-1:0] f,
        input logic [CAP_W-1:0]   cap
    );
        logic [CAP_W-1:0] f_inc;
        f_inc = CAP_W'(f) + 1'b1;
        return (f_inc >= cap) ? '0 : FRAME_W'(f_inc);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [FRAME_W-1:0] f,
        input logic [CHP_W-1:0]   c
    );
        return ADDR_W'(ADDR_W'(f) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(c);
    endfunction

    // Hold off input once the read stage and queue could overflow
    assign in_flight = (OUT_LVL_W + 1)'(q_level) + (OUT_LVL_W + 1)'(a_valid_reg);
    assign s_ready   = (in_flight < (OUT_LVL_W + 1)'(OUT_DEPTH));
    assign s_accept  = s_valid && s_ready;

    // Decode the transaction, move pointers and issue the RAM access
    always_comb begin
        logic [CAP_W-1:0] cnt;
        logic [CHN_W-1:0] wch_inc;
        logic [CHN_W-1:0] rch_inc;

        cnt            = count_reg;
        wch_inc        = CHN_W'(wr_chan_reg) + 1'b1;
        rch_inc        = CHN_W'(rd_chan_reg) + 1'b1;
        wr_frame_next  = wr_frame_reg;
        wr_chan_next   = wr_chan_reg;
        rd_frame_next  = rd_frame_reg;
        rd_chan_next   = rd_chan_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = store_addr(wr_frame_reg, wr_chan_reg);
        ram_raddr      = store_addr(rd_frame_reg, rd_chan_reg);
        a_item_next    = '0;
        a_use_ram_next = 1'b0;

        if (s_accept) begin
            unique case (s_data.opcode)
                OP_WRITE: begin
                    if (s_data.writer_streaming) begin
                        // Drop the oldest frame when a new frame starts on a full buffer
                        if (wr_chan_reg == '0 && cnt >= cap_eff) begin
                            rd_frame_next = next_frame(rd_frame_reg, cap_eff);
                            rd_chan_next  = '0;
                            cnt           = (cnt != '0) ? cnt - 1'b1 : '0;
                            a_item_next.overrun_drop = 1'b1;
                        end
                        ram_we = 1'b1;
                        if (wch_inc >= ch_eff) begin
                            wr_chan_next  = '0;
                            wr_frame_next = next_frame(wr_frame_reg, cap_eff);
                            if (cnt < cap_eff) begin
                                cnt = cnt + 1'b1;
                            end
                        end else begin
                            wr_chan_next = CHP_W'(wch_inc);
                        end
                    end
                end
                OP_READ: begin
                    if (s_data.reader_streaming) begin
                        a_item_next.read_served = 1'b1;
                        if (cnt == '0) begin
                            a_item_next.underrun = 1'b1;
                        end else begin
                            ram_re         = 1'b1;
                            a_use_ram_next = 1'b1;
                            if (rch_inc >= ch_eff) begin
                                rd_chan_next  = '0;
                                rd_frame_next = next_frame(rd_frame_reg, cap_eff);
                                cnt           = cnt - 1'b1;
                            end else begin
                                rd_chan_next = CHP_W'(rch_inc);
                            end
                        end
                    end
                end
                OP_FLUSH: begin
                    wr_frame_next = '0;
                    wr_chan_next  = '0;
                    rd_frame_next = '0;
                    rd_chan_next  = '0;
                    cnt           = '0;
                end
                default: begin
                end
            endcase
        end

        count_next              = cnt;
        a_item_next.fill_frames = FILL_W'(cnt);
        a_item_next.last        = s_data.last_of_batch;
    end

    // Configuration registers and pointer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ch_reg     <= CHANNELS_RESET;
            cfg_frames_reg <= FRAMES_RESET;
            wr_frame_reg   <= '0;
            wr_chan_reg    <= '0;
            rd_frame_reg   <= '0;
            rd_chan_reg    <= '0;
            count_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CHANNELS: cfg_ch_reg     <= cfg_wdata[CFG_CH_W-1:0];
                REG_FRAMES:   cfg_frames_reg <= cfg_wdata[CFG_FRAMES_W-1:0];
                default: begin
                end
            endcase
            wr_frame_reg <= '0;
            wr_chan_reg  <= '0;
            rd_frame_reg <= '0;
            rd_chan_reg  <= '0;
            count_reg    <= '0;
        end else begin
            wr_frame_reg <= wr_frame_next;
            wr_chan_reg  <= wr_chan_next;
            rd_frame_reg <= rd_frame_next;
            rd_chan_reg  <= rd_chan_next;
            count_reg    <= count_next;
        end
    end

    // Read stage: holds the accepted item while the registered RAM read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg    <= a_item_next;
            a_use_ram_reg <= a_use_ram_next;
        end
    end

    afrb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_WORDS)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Merge RAM data into the result
    always_comb begin
        push_item = a_item_reg;
        if (a_use_ram_reg) begin
            push_item.sample_out = ram_rdata;
        end
    end

    afrb_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (a_valid_reg),
        .push_data  (push_item),
        .pop_ready  (m_ready),
        .pop_valid  (m_valid),
        .pop_data   (m_data),
        .level      (q_level)
    );

    // Frame count never exceeds the capacity in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_eff)
    else $error("frame count above capacity");

    // Write channel stays inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        CHN_W'(wr_chan_reg) < ch_eff)
    else $error("write channel out of frame");

    // Read stage plus queue never exceed the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight <= (OUT_LVL_W + 1)'(OUT_DEPTH))
    else $error("result queue overflow");

    // An underrun result is a served read carrying zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.underrun) |-> (m_data.read_served && m_data.sample_out == '0))
    else $error("underrun result carries data");

    // A RAM read is followed by a read stage that uses its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (a_valid_reg && a_use_ram_reg))
    else $error("RAM read data not consumed");

endmodule

`default_nettype wire

// File: bench/audio_frame_ring_buffer_unit_tb.sv
// Self-checking bench for audio_frame_ring_buffer_unit: random and directed sample traffic
// checked against a cycle-free predictor of the frame ring. Depends on afrb_pkg and the RTL.
module audio_frame_ring_buffer_unit_tb;
    import afrb_pkg::*;

    localparam int RING_FRAMES   = 1024;
    localparam int RING_CHANNELS = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CHANNELS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    audio_frame_ring_buffer_unit #(
        .FRAME_SLOTS  (RING_FRAMES),
        .MAX_CHANNELS (RING_CHANNELS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(12 * 400000);
        $display("[audio_frame_ring_buffer_unit] ERROR");
        $finish;
    end

    in_item_t  pending_samples[$];
    out_item_t expected_replies[$];
    int        errors      = 0;
    int        live_items  = 0;
    logic      in_accepted = 1'b0;
    logic      idle_on     = 1'b1;
    int        tx_gap      = 0;
    int        rx_gap      = 0;
    int        rx_freeze   = 0;

    // Predictor state: configuration, sample ring and its pointers
    logic [CFG_CH_W-1:0]     cfg_channels = CHANNELS_RESET;
    logic [CFG_FRAMES_W-1:0] cfg_frames   = FRAMES_RESET;
    logic [SAMPLE_W-1:0]     ring_store [0:RING_FRAMES*RING_CHANNELS-1];
    int wr_frame = 0, wr_chan = 0, rd_frame = 0, rd_chan = 0, held_frames = 0;

    function automatic int ring_channels();
        if (cfg_channels == 0) return 1;
        if (cfg_channels > RING_CHANNELS) return RING_CHANNELS;
        return int'(cfg_channels);
    endfunction

    function automatic int ring_capacity();
        if (cfg_frames == 0) return 1;
        if (cfg_frames > RING_FRAMES) return RING_FRAMES;
        return int'(cfg_frames);
    endfunction

    function automatic int step_frame(input int f, input int cap);
        return (f + 1 >= cap) ? 0 : f + 1;
    endfunction

    function automatic void clear_ring();
        wr_frame    = 0;
        wr_chan     = 0;
        rd_frame    = 0;
        rd_chan     = 0;
        held_frames = 0;
    endfunction

    // Advance the ring by one transaction and return the reply it causes
    function automatic out_item_t ring_predict(input in_item_t it);
        out_item_t r;
        int ch, cap;
        ch  = ring_channels();
        cap = ring_capacity();
        r = '0;
        r.last = it.last_of_batch;
        if (it.opcode == OP_WRITE && it.writer_streaming) begin
            // drop the oldest frame when a new frame starts on a full ring
            if (wr_chan == 0 && held_frames >= cap) begin
                rd_frame = step_frame(rd_frame, cap);
                rd_chan  = 0;
                if (held_frames > 0) held_frames--;
                r.overrun_drop = 1'b1;
            end
            ring_store[wr_frame * RING_CHANNELS + wr_chan] = it.sample;
            if (wr_chan + 1 >= ch) begin
                wr_chan  = 0;
                wr_frame = step_frame(wr_frame, cap);
                if (held_frames < cap) held_frames++;
            end else begin
                wr_chan++;
            end
        end else if (it.opcode == OP_READ && it.reader_streaming) begin
            r.read_served = 1'b1;
            if (held_frames == 0) begin
                r.underrun = 1'b1;
            end else begin
                r.sample_out = ring_store[rd_frame * RING_CHANNELS + rd_chan];
                if (rd_chan + 1 >= ch) begin
                    rd_chan  = 0;
                    rd_frame = step_frame(rd_frame, cap);
                    held_frames--;
                end else begin
                    rd_chan++;
                end
            end
        end else if (it.opcode == OP_FLUSH) begin
            clear_ring();
        end
        r.fill_frames = held_frames[FILL_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            errors++;
        end
    endtask

    // Record accepted transactions and check every reply against the oldest expectation
    always @(posedge aclk) begin : watch_ports
        out_item_t want;
        in_accepted = aresetn && s_valid && s_ready;
        if (in_accepted) expected_replies.push_back(ring_predict(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, got %h", $time, m_data);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                check_field("sample_out", want.sample_out, m_data.sample_out);
                check_field("read_served", want.read_served, m_data.read_served);
                check_field("underrun", want.underrun, m_data.underrun);
                check_field("overrun_drop", want.overrun_drop, m_data.overrun_drop);
                check_field("fill_frames", want.fill_frames, m_data.fill_frames);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    // Sender: hold the payload until accepted, then idle or offer the next transaction
    always @(negedge aclk) begin : drive_samples
        in_item_t nxt_data;
        logic     nxt_valid;
        nxt_data  = s_data;
        nxt_valid = s_valid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_valid || in_accepted) begin
            nxt_valid = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_samples.size() != 0) begin
                nxt_data  = pending_samples.pop_front();
                nxt_valid = 1'b1;
                tx_gap    = idle_on ? draw_gap() : 0;
            end
        end
        s_valid <= nxt_valid;
        s_data  <= nxt_data;
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_freeze > 0) begin
            rx_freeze--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap = idle_on ? draw_gap() : 0;
        end
    end

    task automatic queue_item(input opcode_t op, input logic [SAMPLE_W-1:0] smp,
                              input logic lst, input logic wr, input logic rd);
        in_item_t it;
        it.opcode           = op;
        it.sample           = smp;
        it.last_of_batch    = lst;
        it.writer_streaming = wr;
        it.reader_streaming = rd;
        pending_samples.push_back(it);
        if ((op == OP_WRITE && wr) || (op == OP_READ && rd) || op == OP_FLUSH) live_items++;
    endtask

    // Wait until every queued transaction is sent and every reply has arrived
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CHANNELS) cfg_channels = value[CFG_CH_W-1:0];
        else cfg_frames = value[CFG_FRAMES_W-1:0];
        clear_ring();
        @(posedge aclk);
    endtask

    task automatic set_ring(input int ch, input int frames);
        wait_idle();
        write_reg(REG_CHANNELS, ch);
        write_reg(REG_FRAMES, frames);
    endtask

    // Mostly whole-frame write batches and read batches, with flushes and noise mixed in
    task automatic random_traffic(input int target);
        int goal, ch, cap, r, k, n, i;
        ch   = ring_channels();
        cap  = ring_capacity();
        goal = live_items + target;
        while (live_items < goal) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                k = $urandom_range(1, (cap < 6) ? cap + 1 : 6);
                if (r < 6 && cap * ch <= 64) k = cap + 2;
                n = k * ch;
                if ($urandom_range(0, 6) == 0) n = n + $urandom_range(0, ch - 1);
                for (i = 0; i < n; i++)
                    queue_item(OP_WRITE, $urandom, i == n - 1, 1'b1, $urandom_range(0, 1));
            end else if (r < 85) begin
                n = $urandom_range(1, 3 * ch);
                for (i = 0; i < n; i++)
                    queue_item(OP_READ, $urandom, i == n - 1, $urandom_range(0, 1), 1'b1);
            end else if (r < 89) begin
                queue_item(OP_FLUSH, $urandom, $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (r < 95) begin
                if (r < 92) queue_item(OP_WRITE, $urandom, $urandom_range(0, 1), 1'b0,
                                       $urandom_range(0, 1));
                else queue_item(OP_READ, $urandom, $urandom_range(0, 1),
                                $urandom_range(0, 1), 1'b0);
            end else begin
                queue_item(opcode_t'($urandom_range(0, OP_UNUSED)), $urandom,
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin : stimulus
        int i;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, two channels per frame
        queue_item(OP_READ, 32'h0, 1'b1, 1'b0, 1'b1);         // underrun on empty ring
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b0);         // reader inactive
        queue_item(OP_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1); // writer inactive
        queue_item(OP_WRITE, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b0, 1'b1);         // partial frame only
        queue_item(OP_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_item(OP_WRITE, 32'hA5A5_A5A5, 1'b0, 1'b1, 1'b1);
        queue_item(OP_WRITE, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b1);
        queue_item(opcode_t'(OP_UNUSED), 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b0);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b1, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b1, 1'b1, 1'b1);         // drained
        queue_item(OP_WRITE, 32'h1234_5678, 1'b0, 1'b1, 1'b0);
        queue_item(OP_FLUSH, 32'h0, 1'b1, 1'b0, 1'b0);
        queue_item(OP_READ, 32'h0, 1'b1, 1'b0, 1'b1);         // empty after flush

        // Directed: one-frame ring, drop while the reader is inside the oldest frame
        set_ring(2, 1);
        queue_item(OP_WRITE, $urandom, 1'b0, 1'b1, 1'b1);
        queue_item(OP_WRITE, $urandom, 1'b1, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_WRITE, $urandom, 1'b0, 1'b1, 1'b1);
        queue_item(OP_WRITE, $urandom, 1'b1, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b0, 1'b1, 1'b1);
        queue_item(OP_READ, 32'h0, 1'b1, 1'b1, 1'b1);

        // Out-of-range register values at both ends
        set_ring(0, 0);
        random_traffic(100);
        set_ring(15, 2047);
        random_traffic(120);

        // Fill the full-size ring past capacity while the receiver holds off
        set_ring(1, RING_FRAMES);
        rx_freeze = 300;
        for (i = 0; i < RING_FRAMES + 6; i++)
            queue_item(OP_WRITE, $urandom, i == RING_FRAMES + 5, 1'b1, $urandom_range(0, 1));
        for (i = 0; i < 40; i++)
            queue_item(OP_READ, 32'h0, i == 39, $urandom_range(0, 1), 1'b1);
        random_traffic(50);

        set_ring(3, 4);
        random_traffic(250);

        // Back-to-back stretch with no idling on either side
        set_ring(8, 2);
        idle_on = 1'b0;
        random_traffic(250);
        wait_idle();
        idle_on = 1'b1;

        set_ring(5, 1500);
        random_traffic(150);
        set_ring(2, 3);
        random_traffic(200);

        wait_idle();
        if (errors == 0) begin
            $display("[audio_frame_ring_buffer_unit] OK");
        end else begin
            $display("[audio_frame_ring_buffer_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/afrb_pkg.sv
hdl/afrb_ram.sv
hdl/afrb_out_fifo.sv
hdl/audio_frame_ring_buffer_unit.sv
bench/audio_frame_ring_buffer_unit_tb.sv
